// ===== rtl/pli_pkg.sv =====
`default_nettype none
package pli_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CntW      = 7;
  localparam int unsigned StatW     = 2;
  localparam int unsigned MaxPoints = 64;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_BAD_IDX  = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

  // item as it travels from front to back
  typedef struct packed {
    logic                    opcode;
    logic [IdxW-1:0]         point_index;
    logic signed [DataW-1:0] point_x;
    logic signed [DataW-1:0] point_y;
    logic signed [DataW-1:0] query_x;
  } item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value_y;
    logic [IdxW-1:0]         span_found;
    logic [StatW-1:0]        status;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ENDS,
    BK_SEARCH,
    BK_SPAN,
    BK_MUL,
    BK_DIV,
    BK_FINISH,
    BK_OUT
  } back_state_e;

endpackage
`default_nettype wire

// ===== rtl/pli_item_if.sv =====
`default_nettype none
interface pli_item_if;
  import pli_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pli_result_if.sv =====
`default_nettype none
interface pli_result_if;
  import pli_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pli_cfg_if.sv =====
`default_nettype none
interface pli_cfg_if;
  import pli_pkg::*;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pli_queue.sv =====
`default_nettype none
module pli_queue
  import pli_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  item_t in_data_i,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  output item_t out_data_o
);

  // two-entry queue between front and back
  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

endmodule
`default_nettype wire

// ===== rtl/pli_back.sv =====
`default_nettype none
module pli_back
  import pli_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  item_t           in_data_i,
  input  wire  [CntW-1:0] points_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output result_t         out_data_o
);

  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned MW = 66;  // product magnitude width
  localparam int unsigned DW = 33;  // difference magnitude width

  back_state_e state_q, state_d;

  // table memories, one read port each
  logic signed [DataW-1:0] xs_mem [MaxPoints];
  logic signed [DataW-1:0] ys_mem [MaxPoints];
  logic [AW-1:0]           rd_addr;
  logic signed [DataW-1:0] xr_q, yr_q;

  item_t                   it_q;
  logic [CntW-1:0]         n_q;
  logic [AW:0]             lo_q, hi_q, mid;
  logic signed [DataW-1:0] x0_q, y0_q;
  logic [1:0]              sub_q;
  logic signed [DW:0]      dx_q, dy_q, den_q;
  logic [MW-1:0]           rem_q, quo_q;
  logic [DW-1:0]           dmag_q;
  logic [6:0]              cnt_q;
  logic                    neg_q;
  result_t                 res_q;
  logic                    is_load, idx_ok, n_ok;

  assign is_load = (it_q.opcode == OP_LOAD);
  assign idx_ok  = ({1'b0, it_q.point_index} < (AW+1)'(MaxPoints))
                   || (AW >= IdxW + 1);
  assign n_ok    = (n_q >= CntW'(2)) && ({25'd0, n_q} <= 32'(MaxPoints));
  assign mid     = (lo_q + hi_q) >> 1;

  // read address per step
  always_comb begin
    rd_addr = mid[AW-1:0];
    unique case (state_q)
      BK_ENDS:   rd_addr = (sub_q == 2'd0) ? '0 : AW'(n_q - CntW'(1));
      BK_SPAN:   rd_addr = (sub_q == 2'd0) ? lo_q[AW-1:0] : AW'(lo_q + 1'b1);
      default:   rd_addr = mid[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && in_valid_i && in_data_i.opcode == OP_LOAD &&
        {1'b0, in_data_i.point_index} < (IdxW+1)'(MaxPoints)) begin
      xs_mem[in_data_i.point_index[AW-1:0]] <= in_data_i.point_x;
      ys_mem[in_data_i.point_index[AW-1:0]] <= in_data_i.point_y;
    end
    xr_q <= xs_mem[rd_addr];
    yr_q <= ys_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (in_valid_i) state_d = BK_ENDS;
      BK_ENDS: begin
        if (is_load || !n_ok) state_d = BK_OUT;
        else if (sub_q == 2'd2 && $signed(it_q.query_x) > xr_q) state_d = BK_OUT;
        else if (sub_q == 2'd2) state_d = BK_SEARCH;
        else if (sub_q == 2'd1 && $signed(it_q.query_x) < xr_q) state_d = BK_OUT;
      end
      BK_SEARCH: if (hi_q - lo_q <= 1 && sub_q == 2'd0) state_d = BK_SPAN;
      BK_SPAN:   if (sub_q == 2'd2) state_d = BK_MUL;
      BK_MUL:    state_d = (den_q == '0) ? BK_FINISH : BK_DIV;
      BK_DIV:    if (cnt_q == 7'd0) state_d = BK_FINISH;
      BK_FINISH: state_d = BK_OUT;
      BK_OUT:    if (out_ready_i) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == BK_IDLE);
  assign out_valid_o = (state_q == BK_OUT);
  assign out_data_o  = res_q;

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      sub_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d || (state_q == BK_SEARCH && sub_q == 2'd1)) sub_q <= 2'd0;
      else if (sub_q != 2'd3) sub_q <= sub_q + 2'd1;
    end
  end

  logic [MW:0]   trial;
  always_comb begin
    trial = {rem_q, quo_q[MW-1]} - {{(MW-DW){1'b0}}, 1'b0, dmag_q};
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        it_q  <= in_data_i;
        n_q   <= points_i;
        res_q <= '{value_y: '0, span_found: '0, status: ST_OK};
      end
      BK_ENDS: begin
        if (is_load) begin
          if (!idx_ok) res_q.status <= ST_BAD_IDX;
        end else if (!n_ok) res_q.status <= ST_BAD_IDX;
        else if (sub_q != 2'd0 && state_d == BK_OUT) res_q.status <= ST_RANGE;
        lo_q <= '0;
        hi_q <= (AW+1)'(n_q - CntW'(1));
      end
      BK_SEARCH: begin
        // each probe: address the midpoint, then registered compare
        if (sub_q == 2'd1) begin
          if ($signed(it_q.query_x) >= xr_q) lo_q <= mid;
          else hi_q <= mid;
        end
      end
      BK_SPAN: begin
        if (sub_q == 2'd1) begin
          x0_q <= xr_q;
          y0_q <= yr_q;
        end
        if (sub_q == 2'd2) begin
          dx_q  <= (DW+1)'($signed(it_q.query_x)) - (DW+1)'(x0_q);
          dy_q  <= (DW+1)'(yr_q) - (DW+1)'(y0_q);
          den_q <= (DW+1)'(xr_q) - (DW+1)'(x0_q);
        end
      end
      BK_MUL: begin
        quo_q  <= MW'((dx_q[DW] ? DW'(-dx_q) : DW'(dx_q)) *
                      (dy_q[DW] ? DW'(-dy_q) : DW'(dy_q)));
        dmag_q <= den_q[DW] ? DW'(-den_q) : DW'(den_q);
        neg_q  <= (dx_q[DW] ^ dy_q[DW]) ^ den_q[DW];
        rem_q  <= '0;
        cnt_q  <= 7'(MW - 1);
      end
      BK_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!trial[MW]) rem_q <= trial[MW-1:0];
        else rem_q <= {rem_q[MW-2:0], quo_q[MW-1]};
        quo_q <= {quo_q[MW-2:0], ~trial[MW]};
        cnt_q <= cnt_q - 7'd1;
      end
      BK_FINISH: begin
        logic [MW-1:0] qs;
        logic signed [MW+1:0] r;
        qs = (den_q == '0) ? '0 :
             ((quo_q > (MW'(1) << 34)) ? (MW'(1) << 34) : quo_q);
        r  = (MW+2)'(y0_q) + (neg_q ? -$signed({2'b00, qs}) : $signed({2'b00, qs}));
        if (r > (MW+2)'(32'sh7fffffff)) res_q.value_y <= 32'sh7fffffff;
        else if (r < -(MW+2)'(33'sh080000000)) res_q.value_y <= 32'sh80000000;
        else res_q.value_y <= r[DataW-1:0];
        res_q.span_found <= IdxW'(lo_q);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pli_front.sv =====
`default_nettype none
module pli_front
  import pli_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  pli_item_if.sink        in_if,
  pli_cfg_if.sink         cfg_if,
  output logic [CntW-1:0] points_o,
  output logic            q_valid_o,
  input  wire             q_ready_i,
  output item_t           q_data_o
);

  logic [CntW-1:0] points_q;

  // points register, sampled by the back when it takes an item
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) points_q <= CntW'(2);
    else if (cfg_if.valid) points_q <= cfg_if.data;
  end

  assign points_o     = points_q;
  assign q_valid_o    = in_if.valid;
  assign in_if.ready  = q_ready_i;
  // normalize opcode and pass to queue
  always_comb begin
    q_data_o        = in_if.data;
    q_data_o.opcode = (in_if.data.opcode == OP_QUERY) ? OP_QUERY : OP_LOAD;
  end

endmodule
`default_nettype wire

// ===== rtl/piecewise_linear_interpolator_core.sv =====
// piecewise linear interpolator core
// channels: in_if carries a transaction per item (load of one breakpoint or a
// query at query_x), out_if returns exactly one result per item in order, and
// cfg_if writes points_in_use (7 bits, reset 2); write it only with no item
// in flight, the back samples it when it takes each item.
// a load or a query with a bad point count goes from the end checks straight
// to the result; a query outside the table stops at the end check that fails.
// a query in range passes the queue, the end checks, a binary search over the
// table, the span fetch, one multiply, a restoring division of 66 quotient
// bits and a final add.
// the back holds one item; it takes the next item only after the result is
// taken, and for queries the divider sets the rate.
// a stalled receiver holds the back; the two-entry queue then fills and the
// input stalls; the result stays until taken.
// reset clears control and sets points_in_use to 2; table contents are
// undefined until loaded.
`default_nettype none
module piecewise_linear_interpolator_core
  import pli_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  pli_item_if.sink       in_if,
  pli_result_if.source   out_if,
  pli_cfg_if.sink        cfg_if
);

  item_t           f_data, q_data;
  logic            f_valid, f_ready, q_valid, q_ready;
  logic [CntW-1:0] points;

  pli_front u_front (
    .clk_i, .rst_ni, .in_if, .cfg_if,
    .points_o(points), .q_valid_o(f_valid), .q_ready_i(f_ready), .q_data_o(f_data)
  );

  pli_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_data),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  pli_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .points_i(points),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );

endmodule
`default_nettype wire

// ===== rtl/pli_checker.sv =====
`default_nettype none
module pli_checker
  import pli_pkg::*;
(
  input wire     clk_i,
  input wire     rst_ni,
  input wire     out_valid_i,
  input wire     out_ready_i,
  input result_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.status != ST_RESERVED)
    else $error("reserved status");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != ST_OK |-> out_data_i.value_y == '0 &&
    out_data_i.span_found == '0)
    else $error("failed result not zero");

endmodule

bind piecewise_linear_interpolator_core pli_checker u_chk (
  .clk_i, .rst_ni,
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);
`default_nettype wire

// ===== tb/sv/tb_if.sv =====
`timescale 1ns / 1ps
// channel interfaces come from the rtl; this file only holds a tiny helper type
package tb_pli_pkg;
  import pli_pkg::*;

  // one expected result
  typedef struct packed {
    logic signed [DataW-1:0] value_y;
    logic [IdxW-1:0]         span_found;
    status_e                 status;
  } expect_t;
endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import pli_pkg::*;
  import tb_pli_pkg::*;

  localparam int unsigned NPTS = 64;
  localparam int unsigned WDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pli_item_if   in_if ();
  pli_result_if out_if ();
  pli_cfg_if    cfg_if ();

  piecewise_linear_interpolator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [63:0] knot_x [NPTS];
  logic signed [63:0] knot_y [NPTS];
  logic [CntW-1:0]    live_points;
  longint             knot_x_shadow [NPTS];

  item_t   pending_items [$];
  expect_t expected_results [$];
  int      err_count;
  int      idle_cycles;
  int      hold_off_cycles;
  int      in_gap;
  int      out_gap;

  // interpolate one span with saturation
  function automatic logic signed [31:0] lerp(logic signed [63:0] x,
      logic signed [63:0] x0, logic signed [63:0] y0,
      logic signed [63:0] x1, logic signed [63:0] y1);
    logic signed [63:0] dx, dy, den, r;
    logic [63:0] mx, my, md;
    logic [63:0] q;
    bit neg;
    dx = x - x0;
    dy = y1 - y0;
    den = x1 - x0;
    if (den == 0) return y0[31:0];
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    md = den < 0 ? -den : den;
    q = (mx * my) / md;
    if (q > (64'd1 << 34)) q = 64'd1 << 34;
    neg = ((dx < 0) != (dy < 0)) != (den < 0);
    r = y0 + (neg ? -$signed(q) : $signed(q));
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // expected result of one accepted item, updates the table copy
  function automatic expect_t interpolate_item(item_t it);
    expect_t e;
    logic signed [63:0] x;
    int n, lo, hi, mid;
    e = '0;
    e.status = ST_OK;
    if (it.opcode == OP_LOAD) begin
      knot_x[it.point_index] = it.point_x;
      knot_y[it.point_index] = it.point_y;
    end else begin
      n = live_points;
      x = it.query_x;
      if (n < 2 || n > NPTS) begin
        e.status = ST_BAD_IDX;
      end else if (x < knot_x[0] || x > knot_x[n-1]) begin
        e.status = ST_RANGE;
      end else begin
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          if (x >= knot_x[mid]) lo = mid;
          else hi = mid;
        end
        e.span_found = lo[IdxW-1:0];
        e.value_y = lerp(x, knot_x[lo], knot_y[lo], knot_x[lo+1], knot_y[lo+1]);
      end
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
      in_gap <= 0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold offer
    end else begin
      if (in_if.valid) begin
        expected_results.push_back(interpolate_item(in_if.data));
      end
      if (in_gap > 0 || pending_items.size() == 0) begin
        in_if.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        in_if.valid <= 1'b1;
        in_if.data <= pending_items.pop_front();
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    expect_t e;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_if.data.value_y !== e.value_y)
            report_mismatch("value_y", out_if.data.value_y, e.value_y);
          if (out_if.data.span_found !== e.span_found)
            report_mismatch("span_found", out_if.data.span_found, e.span_found);
          if (out_if.data.status !== e.status)
            report_mismatch("status", out_if.data.status, e.status);
        end
        out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        out_if.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off counter
  always @(posedge clk_i) if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;

  // watchdog on accepted transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_points(logic [CntW-1:0] n);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= n;
    do @(posedge clk_i); while (!cfg_if.ready);
    live_points = n;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic item_t load_item(int idx, logic [31:0] px, logic [31:0] py);
    item_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.point_index = idx[IdxW-1:0];
    it.point_x = px;
    it.point_y = py;
    it.query_x = $urandom;
    return it;
  endfunction

  function automatic item_t query_item(logic [31:0] qx);
    item_t it;
    it.opcode = OP_QUERY;
    it.point_index = IdxW'($urandom);
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.query_x = qx;
    return it;
  endfunction

  // fill all slots: the first n with a strictly increasing random table spanning [lo, hi], the rest at hi
  task automatic load_table(longint lo_x, longint hi_x, int n);
    longint step, x;
    for (int i = 0; i < NPTS; i++) begin
      if (i < n) begin
        step = (hi_x - lo_x) / (n - 1);
        x = (i == n - 1) ? hi_x : lo_x + step * i + (step > 4 ? $urandom_range(0, step / 4) : 0);
      end else begin
        x = hi_x;
      end
      pending_items.push_back(load_item(i, x[31:0], $urandom));
    end
  endtask

  task automatic random_queries(int cnt, int n);
    int k;
    logic [31:0] qx;
    longint a, b;
    for (int i = 0; i < cnt; i++) begin
      k = $urandom_range(0, n - 2);
      a = knot_x_shadow[k];
      b = knot_x_shadow[k+1];
      case ($urandom_range(0, 9))
        0: qx = $urandom;
        1: qx = a[31:0];
        2: qx = b[31:0];
        default: qx = 32'(a + longint'($urandom) % (b - a + 1));
      endcase
      pending_items.push_back(query_item(qx));
    end
  endtask

  // remember planned abscissas from queued loads
  task automatic shadow_loads();
    foreach (pending_items[i])
      if (pending_items[i].opcode == OP_LOAD)
        knot_x_shadow[pending_items[i].point_index] = pending_items[i].point_x;
  endtask

  initial begin
    int n;
    err_count = 0;
    hold_off_cycles = 0;
    live_points = 2;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    foreach (knot_x[i]) begin
      knot_x[i] = 0;
      knot_y[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes on a two-point table, then load slot 63 and reload slot 1
    pending_items.push_back(load_item(0, 32'h8000_0000, 32'h7fff_ffff));
    pending_items.push_back(load_item(1, 32'h7fff_ffff, 32'h8000_0000));
    pending_items.push_back(query_item(32'h8000_0000));
    pending_items.push_back(query_item(32'h7fff_ffff));
    pending_items.push_back(query_item(32'h0000_0000));
    pending_items.push_back(query_item(32'hffff_ffff));
    pending_items.push_back(load_item(63, 32'h7fff_ffff, 32'h0));
    pending_items.push_back(load_item(1, 32'h0001_0000, 32'h0002_0000));
    pending_items.push_back(query_item(32'h0001_0001));
    pending_items.push_back(query_item(32'h8000_0000));
    wait_drained();
    // bad point counts and equal abscissas
    write_points(0);
    pending_items.push_back(query_item(32'h0));
    wait_drained();
    write_points(1);
    pending_items.push_back(query_item(32'h0));
    wait_drained();
    write_points(127);
    pending_items.push_back(query_item(32'h0));
    wait_drained();
    write_points(2);
    pending_items.push_back(load_item(0, 32'h10, 32'h5));
    pending_items.push_back(load_item(1, 32'h10, 32'h9));
    pending_items.push_back(query_item(32'h10));
    wait_drained();

    // random phases over several point counts
    for (int ph = 0; ph < 8; ph++) begin
      n = (ph == 0) ? 64 : (ph == 1) ? 2 : $urandom_range(2, 64);
      write_points(n[CntW-1:0]);
      if (ph % 2) load_table(-64'sd2147483648, 64'sd2147483647, n);
      else load_table(-longint'($urandom_range(0, 1 << 20)), $urandom_range(1, 1 << 20), n);
      shadow_loads();
      random_queries(130, n);
      if (ph == 2) begin
        wait (pending_items.size() < 120);
        hold_off_cycles = 400;
      end
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
